[hdl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; take in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define MBPE_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that also holds during reset
`define MBPE_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[hdl/mbpe_pkg.sv]
// shared types and constants of the mono bitmap pixel expander
// no dependencies
`timescale 1ns / 1ps

package mbpe_pkg;

    localparam int ADDR_W     = 18;
    localparam int COLOR_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 4;   // 1..8 pixels per byte
    localparam int IDX_W      = 3;
    localparam int ROW_W      = 9;
    localparam int COL_W      = 10;
    localparam int OX_W       = 9;
    localparam int OY_W       = 8;
    localparam int WID_W      = 9;
    localparam int HGT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 40;  // address and color, padded to bytes

    localparam int DEF_STRIDE     = 320;
    localparam int DEF_FIFO_DEPTH = 2;

    localparam logic [CNT_W-1:0] PIX_PER_BYTE = 4'd8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COLOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_COLOR = 3'd5;

    localparam logic [COLOR_W-1:0] RST_SET_COLOR   = 16'h8430;
    localparam logic [COLOR_W-1:0] RST_CLEAR_COLOR = 16'h0000;
    localparam logic [WID_W-1:0]   RST_WIDTH       = 9'd1;
    localparam logic [HGT_W-1:0]   RST_HEIGHT      = 8'd1;

    typedef struct packed {
        logic [OX_W-1:0]    origin_x;
        logic [OY_W-1:0]    origin_y;
        logic [WID_W-1:0]   width;
        logic [HGT_W-1:0]   height;
        logic [COLOR_W-1:0] set_color;
        logic [COLOR_W-1:0] clear_color;
    } t_cfg;

    // one byte worth of pixel work, handed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] base_addr;
        logic [BYTE_W-1:0] bits;
        logic [CNT_W-1:0]  count;
        logic              done;
    } t_cmd;

endpackage

[hdl/mbpe_front.sv]
// front end: accepts bitmap bytes, tracks row and column, builds pixel commands
// depends on mbpe_pkg
`timescale 1ns / 1ps

module mbpe_front import mbpe_pkg::*; #(
    parameter int STRIDE = DEF_STRIDE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_q_wr,
    output t_cmd              o_q_cmd
);

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;

    logic [WID_W-1:0]  w_w;
    logic [HGT_W-1:0]  w_h;
    logic [ROW_W-1:0]  w_r0;
    logic [ROW_W-1:0]  w_r1;
    logic [ROW_W-1:0]  w_r1_inc;
    logic [COL_W-1:0]  w_c1;
    logic [COL_W-1:0]  w_remain;
    logic [CNT_W-1:0]  w_count;
    logic [COL_W-1:0]  w_col_end;
    logic              w_row_end;
    logic [ROW_W:0]    w_row_sum;
    logic [ADDR_W-1:0] w_base;
    logic              w_acc;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        w_w = (i_cfg.width == '0) ? WID_W'(1) : i_cfg.width;
        w_h = (i_cfg.height == '0) ? HGT_W'(1) : i_cfg.height;

        // shrunk height: row restarts at the top
        w_r0 = (r_row >= ROW_W'(w_h)) ? '0 : r_row;

        // shrunk width: the row counts as finished
        if (r_col >= COL_W'(w_w)) begin
            w_c1     = '0;
            w_r1_inc = w_r0 + ROW_W'(1);
            w_r1     = (w_r1_inc >= ROW_W'(w_h)) ? '0 : w_r1_inc;
        end else begin
            w_c1     = r_col;
            w_r1_inc = w_r0;
            w_r1     = w_r0;
        end

        w_remain  = COL_W'(w_w) - w_c1;
        w_count   = (w_remain < COL_W'(PIX_PER_BYTE)) ? CNT_W'(w_remain) : PIX_PER_BYTE;
        w_col_end = w_c1 + COL_W'(w_count);
        w_row_end = (w_col_end >= COL_W'(w_w));

        w_row_sum = (ROW_W+1)'(i_cfg.origin_y) + (ROW_W+1)'(w_r1);
        w_base    = ADDR_W'(w_row_sum) * ADDR_W'(STRIDE)
                  + ADDR_W'(i_cfg.origin_x) + ADDR_W'(w_c1);

        o_q_cmd.base_addr = w_base;
        o_q_cmd.bits      = i_byte;
        o_q_cmd.count     = w_count;
        o_q_cmd.done      = w_row_end && ((w_r1 + ROW_W'(1)) >= ROW_W'(w_h));

        n_row = r_row;
        n_col = r_col;
        if (w_acc) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = ((w_r1 + ROW_W'(1)) >= ROW_W'(w_h)) ? '0 : w_r1 + ROW_W'(1);
            end else begin
                n_col = w_col_end;
                n_row = w_r1;
            end
        end
    end

    assign o_q_wr = w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

[hdl/mbpe_fifo.sv]
// short command queue between front and back ends
// depends on mbpe_pkg
`timescale 1ns / 1ps

module mbpe_fifo import mbpe_pkg::*; #(
    parameter int DEPTH = DEF_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= f_inc(r_wp);
            end
            if (i_rd) begin
                r_rp <= f_inc(r_rp);
            end
            r_cnt <= r_cnt + (AW+1)'(i_wr) - (AW+1)'(i_rd);
        end
    end

endmodule

[hdl/mbpe_back.sv]
// back end: walks the pixels of the head command, one registered pixel per cycle while the receiver is ready
// depends on mbpe_pkg
`timescale 1ns / 1ps

module mbpe_back import mbpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_cmd               i_q_cmd,
    output logic               o_q_rd,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ADDR_W-1:0]  o_addr,
    output logic [COLOR_W-1:0] o_color,
    output logic               o_last,
    output logic               o_done
);

    logic [IDX_W-1:0]   r_idx;
    logic               r_valid;
    logic [ADDR_W-1:0]  r_addr;
    logic [COLOR_W-1:0] r_color;
    logic               r_last;
    logic               r_done;

    logic w_adv;
    logic w_emit;
    logic w_last;
    logic w_bit;

    assign w_adv  = !r_valid || i_ready;
    assign w_emit = w_adv && !i_q_empty;
    assign w_last = ((CNT_W'(r_idx) + CNT_W'(1)) == i_q_cmd.count);
    assign w_bit  = i_q_cmd.bits[IDX_W'(BYTE_W - 1) - r_idx];
    assign o_q_rd = w_emit && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_valid <= !i_q_empty;
            end
            if (w_emit) begin
                r_idx <= w_last ? '0 : r_idx + IDX_W'(1);
            end
        end
        if (w_emit) begin
            r_addr  <= i_q_cmd.base_addr + ADDR_W'(r_idx);
            r_color <= w_bit ? i_cfg.set_color : i_cfg.clear_color;
            r_last  <= w_last;
            r_done  <= w_last && i_q_cmd.done;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_color = r_color;
    assign o_last  = r_last;
    assign o_done  = r_done;

endmodule

[hdl/mono_bitmap_pixel_expander.sv]
// top level of the 1bpp to rgb565 bitmap pixel expander
// depends on mbpe_pkg, mbpe_front, mbpe_fifo, mbpe_back
`timescale 1ns / 1ps

// Takes a stream of 1bpp bitmap bytes (leftmost pixel in bit 7) and expands each
// into 1 to 8 pixel write transactions of {address, rgb565 color}; every row of
// the rectangle starts on a fresh byte, and the final byte of a row gives only the
// pixels left in it. Address = (origin_y + row) * STRIDE + origin_x + column,
// kept modulo 2^18. The output carries one pixel per clock while the receiver
// is ready; the pixel counter of the back end steps through the pixels of a byte.
// The front end takes a byte every cycle while the command queue (DEF_FIFO_DEPTH
// entries) has room, and keeps doing so while a pixel waits in the output
// register. A byte is written into the command queue and its first pixel is
// registered from there into the output register. tlast marks the last pixel of
// each byte, tuser the last pixel of the whole bitmap, after which the position
// returns to the origin. Width or height of zero acts as one. Write the registers
// only while no pixels are pending; they apply from the next byte on.

module mono_bitmap_pixel_expander import mbpe_pkg::*; #(
    parameter int STRIDE     = DEF_STRIDE,
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // bitmap byte stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,    // [7:0] bitmap_byte
    // pixel write stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,    // [17:0] pixel_address, [33:18] pixel_color
    output logic                  m_axis_tlast,    // last_of_byte
    output logic                  m_axis_tuser     // [0] bitmap_done
);

    t_cfg r_cfg;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.width       <= RST_WIDTH;
            r_cfg.height      <= RST_HEIGHT;
            r_cfg.set_color   <= RST_SET_COLOR;
            r_cfg.clear_color <= RST_CLEAR_COLOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg_data[OX_W-1:0];
                CFG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg_data[OY_W-1:0];
                CFG_WIDTH:       r_cfg.width       <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT:      r_cfg.height      <= i_cfg_data[HGT_W-1:0];
                CFG_SET_COLOR:   r_cfg.set_color   <= i_cfg_data[COLOR_W-1:0];
                CFG_CLEAR_COLOR: r_cfg.clear_color <= i_cfg_data[COLOR_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // front to queue
    logic w_q_wr;
    t_cmd w_q_in;
    logic w_q_full;
    // queue to back
    logic w_q_rd;
    logic w_q_empty;
    t_cmd w_q_out;

    logic [ADDR_W-1:0]  w_addr;
    logic [COLOR_W-1:0] w_color;

    mbpe_front #(
        .STRIDE (STRIDE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_q_full (w_q_full),
        .o_q_wr   (w_q_wr),
        .o_q_cmd  (w_q_in)
    );

    mbpe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_cmd   (w_q_in),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_empty (w_q_empty),
        .o_cmd   (w_q_out)
    );

    mbpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_q_cmd   (w_q_out),
        .o_q_rd    (w_q_rd),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_addr    (w_addr),
        .o_color   (w_color),
        .o_last    (m_axis_tlast),
        .o_done    (m_axis_tuser)
    );

    // pack address low, color above, zero pad to whole bytes
    assign m_axis_tdata = {(OUT_DATA_W - ADDR_W - COLOR_W)'(0), w_color, w_addr};

endmodule

[hdl/mbpe_checker.sv]
// port level checker for the bitmap pixel expander, bound to the top level
// depends on mbpe_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbpe_checker import mbpe_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser
);

    // a stalled pixel holds
    `MBPE_ASSERT_RST(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // end of bitmap is always the end of a byte
    `MBPE_ASSERT_RST(a_done_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)

    // pixels of one byte run at consecutive addresses
    `MBPE_ASSERT_RST(a_addr_step, i_clk, i_rst_n, $past(i_rst_n) && $past(m_axis_tvalid && m_axis_tready && !m_axis_tlast) && m_axis_tvalid |-> m_axis_tdata[ADDR_W-1:0] == $past(m_axis_tdata[ADDR_W-1:0]) + ADDR_W'(1))

    // nothing comes out right after reset
    `MBPE_ASSERT_ALL(a_rst_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind mono_bitmap_pixel_expander mbpe_checker u_mbpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_mono_bitmap_pixel_expander.sv]
// self-checking testbench for mono_bitmap_pixel_expander: directed table then random phases
// depends on mbpe_pkg and the rtl of mono_bitmap_pixel_expander
`timescale 1ns / 1ps

module tb_mono_bitmap_pixel_expander;
    import mbpe_pkg::*;

    localparam int STRIDE        = DEF_STRIDE;
    localparam int RANDOM_BYTES  = 413;   // random stimulus stops once this many were sent
    localparam int QUIET_TAIL    = 80;    // last random bytes run with no idling
    localparam int SETTLE_CYCLES = 8;     // extra wait after the last owed pixel
    localparam int MAX_PHASE     = 130;

    // index codes with no register behind them, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // one pixel write as seen on the master stream
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               done;
    } t_pixel;

    // one row of the directed table: a register write or a byte, optionally a typed pixel
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [BYTE_W-1:0]     bits;
        logic                  typed;
        t_pixel                px;
    } t_plan;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;    // [7:0] bitmap_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // [17:0] pixel_address, [33:18] pixel_color
    logic                  m_axis_tlast;    // last_of_byte
    logic                  m_axis_tuser;    // [0] bitmap_done

    mono_bitmap_pixel_expander #(
        .STRIDE     (STRIDE),
        .FIFO_DEPTH (DEF_FIFO_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // shadow of the geometry and color registers
    int unsigned geo_origin_x;
    int unsigned geo_origin_y;
    int unsigned geo_width;
    int unsigned geo_height;
    logic [COLOR_W-1:0] ink_set;
    logic [COLOR_W-1:0] ink_clear;

    // walk position inside the bitmap
    int unsigned cur_row;
    int unsigned cur_col;

    t_pixel pixel_q[$];     // pixels still owed by the block, oldest first
    t_plan  plan_q[$];

    int errors;
    int n_bytes;
    int n_directed;
    int n_pixels;
    int n_writes;
    int n_settings;
    bit quiet;              // no idling on either side
    int stall_left;

    // register write into the shadow copy, data masked to the register width
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ORIGIN_X:    geo_origin_x = data[OX_W-1:0];
            CFG_ORIGIN_Y:    geo_origin_y = data[OY_W-1:0];
            CFG_WIDTH:       geo_width    = data[WID_W-1:0];
            CFG_HEIGHT:      geo_height   = data[HGT_W-1:0];
            CFG_SET_COLOR:   ink_set      = data;
            CFG_CLEAR_COLOR: ink_clear    = data;
            default: ;
        endcase
    endfunction

    // queue the pixel writes that one accepted bitmap byte must produce
    function automatic void expand_byte(input logic [BYTE_W-1:0] bits);
        int unsigned w;
        int unsigned h;
        int unsigned remaining;
        int unsigned count;
        int unsigned base;
        logic        row_end;
        logic        bitmap_end;
        t_pixel      px;
        w = (geo_width == 0) ? 1 : geo_width;
        h = (geo_height == 0) ? 1 : geo_height;
        // a height shrunk under the current row restarts the bitmap
        if (cur_row >= h)
            cur_row = 0;
        // a width shrunk under the current column closes the row first
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h)
                cur_row = 0;
        end
        remaining  = w - cur_col;
        count      = (remaining < 8) ? remaining : 8;
        row_end    = (cur_col + count >= w);
        bitmap_end = row_end && (cur_row + 1 >= h);
        base = (geo_origin_y + cur_row) * STRIDE + geo_origin_x + cur_col;
        for (int unsigned i = 0; i < count; i++) begin
            px.addr  = ADDR_W'(base + i);
            px.color = bits[7 - i] ? ink_set : ink_clear;
            px.last  = (i + 1 == count);
            px.done  = px.last && bitmap_end;
            pixel_q.push_back(px);
        end
        if (row_end) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h)
                cur_row = 0;
        end else begin
            cur_col += count;
        end
        cur_col &= 32'h3FF;
        cur_row &= 32'h1FF;
    endfunction

    // register write transaction, the stream must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one byte transaction; a typed pixel replaces the computed one for single-pixel bytes
    task automatic send_byte(input logic [BYTE_W-1:0] bits, input logic typed,
                             input t_pixel px);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        do @(posedge i_clk); while (!s_axis_tready);
        expand_byte(bits);
        if (typed) begin
            void'(pixel_q.pop_back());
            pixel_q.push_back(px);
        end
        n_bytes++;
    endtask

    // stop the stream and wait until every owed pixel came out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // directed table builders
    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        t_plan p;
        p        = '0;
        p.is_cfg = 1'b1;
        p.idx    = idx;
        p.data   = data;
        plan_q.push_back(p);
    endfunction

    function automatic void plan_byte(input logic [BYTE_W-1:0] bits);
        t_plan p;
        p      = '0;
        p.bits = bits;
        plan_q.push_back(p);
    endfunction

    function automatic void plan_pixel(input logic [BYTE_W-1:0] bits,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [COLOR_W-1:0] color);
        t_plan p;
        p          = '0;
        p.bits     = bits;
        p.typed    = 1'b1;
        p.px.addr  = addr;
        p.px.color = color;
        p.px.last  = 1'b1;      // width one: every byte is one whole bitmap
        p.px.done  = 1'b1;
        plan_q.push_back(p);
    endfunction

    // receiver: ready drops now and then in bursts of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // pixel checker: every accepted pixel transaction against the oldest owed pixel
    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_pixels++;
            if (pixel_q.size() == 0) begin
                errors++;
                $error("pixel transaction with none owed, address %0d", m_axis_tdata[17:0]);
            end else begin
                want = pixel_q.pop_front();
                if (m_axis_tdata[17:0] !== want.addr) begin
                    errors++;
                    $error("pixel_address: expected %0d, got %0d", want.addr,
                           m_axis_tdata[17:0]);
                end
                if (m_axis_tdata[33:18] !== want.color) begin
                    errors++;
                    $error("pixel_color: expected 0x%04h, got 0x%04h", want.color,
                           m_axis_tdata[33:18]);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $error("last_of_byte: expected %0b, got %0b", want.last, m_axis_tlast);
                end
                if (m_axis_tuser !== want.done) begin
                    errors++;
                    $error("bitmap_done: expected %0b, got %0b", want.done, m_axis_tuser);
                end
            end
        end
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("mono_bitmap_pixel_expander: mismatch");
        $finish;
    end

    initial begin : stimulus
        int unsigned w_pick;
        int unsigned h_pick;
        int unsigned we;
        int unsigned he;
        int unsigned per_bitmap;
        int unsigned burst;
        int unsigned sel;
        int unsigned left;
        logic [BYTE_W-1:0] bits;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ORIGIN_X;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        quiet         = 1'b0;
        errors        = 0;
        n_bytes       = 0;
        n_pixels      = 0;
        n_writes      = 0;
        n_settings    = 1;

        // shadow starts from the reset values
        geo_origin_x = 0;
        geo_origin_y = 0;
        geo_width    = RST_WIDTH;
        geo_height   = RST_HEIGHT;
        ink_set      = RST_SET_COLOR;
        ink_clear    = RST_CLEAR_COLOR;
        cur_row      = 0;
        cur_col      = 0;

        // ---- directed table ----
        // reset settings: one pixel bitmap at the origin
        plan_pixel(8'h80, 18'd0, RST_SET_COLOR);
        plan_pixel(8'h7F, 18'd0, RST_CLEAR_COLOR);
        // far corner of the screen, color extremes
        plan_cfg(CFG_ORIGIN_X, 16'd319);
        plan_cfg(CFG_ORIGIN_Y, 16'd239);
        plan_cfg(CFG_SET_COLOR, 16'hFFFF);
        plan_cfg(CFG_CLEAR_COLOR, 16'h0000);
        plan_pixel(8'hFF, 18'd76799, 16'hFFFF);
        plan_pixel(8'h00, 18'd76799, 16'h0000);
        // origin beyond the screen, upper data bits dropped by the register width
        plan_cfg(CFG_ORIGIN_X, 16'hFFFF);
        plan_cfg(CFG_ORIGIN_Y, 16'hFFFF);
        plan_cfg(CFG_SET_COLOR, 16'h0000);
        plan_cfg(CFG_CLEAR_COLOR, 16'hFFFF);
        plan_pixel(8'h80, 18'd82111, 16'h0000);
        // zero width and height behave as one
        plan_cfg(CFG_ORIGIN_X, 16'd0);
        plan_cfg(CFG_ORIGIN_Y, 16'd0);
        plan_cfg(CFG_WIDTH, 16'd0);
        plan_cfg(CFG_HEIGHT, 16'd0);
        plan_pixel(8'h01, 18'd0, 16'hFFFF);
        // two rows of 13 pixels: full byte then a five pixel tail
        plan_cfg(CFG_ORIGIN_X, 16'd7);
        plan_cfg(CFG_ORIGIN_Y, 16'd3);
        plan_cfg(CFG_WIDTH, 16'd13);
        plan_cfg(CFG_HEIGHT, 16'd2);
        plan_cfg(CFG_SET_COLOR, 16'h1234);
        plan_cfg(CFG_CLEAR_COLOR, 16'hABCD);
        plan_byte(8'hA5);
        plan_byte(8'h3C);
        plan_byte(8'hFF);
        plan_byte(8'h0F);
        // width shrunk in the middle of a row closes that row
        plan_cfg(CFG_WIDTH, 16'd20);
        plan_cfg(CFG_HEIGHT, 16'd3);
        plan_byte(8'h55);
        plan_cfg(CFG_WIDTH, 16'd5);
        plan_byte(8'hF0);
        plan_byte(8'h88);
        // height shrunk under the current row restarts the bitmap
        plan_byte(8'h11);
        plan_byte(8'hEE);
        plan_cfg(CFG_HEIGHT, 16'd2);
        plan_byte(8'h96);
        // spare indexes change nothing
        plan_cfg(CFG_SPARE_7, 16'hFFFF);
        plan_cfg(CFG_SPARE_6, 16'h0000);
        plan_byte(8'hC3);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_q[k]) begin
            if (plan_q[k].is_cfg) begin
                if (k == 0 || !plan_q[k - 1].is_cfg) begin
                    drain();
                    n_settings++;
                end
                write_reg(plan_q[k].idx, plan_q[k].data);
            end else begin
                send_byte(plan_q[k].bits, plan_q[k].typed, plan_q[k].px);
            end
        end
        n_directed = n_bytes;

        // ---- random phases: new settings, then whole bitmaps or a partial run ----
        while (n_bytes - n_directed < RANDOM_BYTES) begin
            drain();
            n_settings++;
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // one or two wide rows, beyond the screen now and then
                w_pick = $urandom_range(0, 1) ? 320 : 511;
                h_pick = $urandom_range(0, 2);
            end else if (sel == 1) begin
                w_pick = $urandom_range(0, 1) ? 0 : 8;
                h_pick = $urandom_range(0, 12);
            end else begin
                w_pick = $urandom_range(1, 40);
                h_pick = $urandom_range(1, 8);
            end
            // random upper bits ride along and are dropped by the register width
            write_reg(CFG_ORIGIN_X, {7'($urandom),
                      9'(($urandom_range(0, 9) == 0) ? 511 : $urandom_range(0, 319))});
            write_reg(CFG_ORIGIN_Y, {8'($urandom),
                      8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 239))});
            write_reg(CFG_WIDTH, {7'($urandom), 9'(w_pick)});
            write_reg(CFG_HEIGHT, {8'($urandom), 8'(h_pick)});
            case ($urandom_range(0, 5))
                0: write_reg(CFG_SET_COLOR, 16'hFFFF);
                1: write_reg(CFG_SET_COLOR, 16'h0000);
                default: write_reg(CFG_SET_COLOR, 16'($urandom));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_CLEAR_COLOR, 16'h0000);
                1: write_reg(CFG_CLEAR_COLOR, 16'hFFFF);
                default: write_reg(CFG_CLEAR_COLOR, 16'($urandom));
            endcase

            we = (w_pick == 0) ? 1 : w_pick;
            he = (h_pick == 0) ? 1 : h_pick;
            per_bitmap = ((we + 7) / 8) * he;
            // mostly whole bitmaps, sometimes a run that stops mid bitmap
            if ($urandom_range(0, 3) == 0)
                burst = $urandom_range(1, 30);
            else
                burst = per_bitmap * $urandom_range(1, 2);
            if (burst > MAX_PHASE)
                burst = MAX_PHASE;
            // never run past the planned byte count
            left = RANDOM_BYTES - (n_bytes - n_directed);
            if (burst > left)
                burst = left;

            for (int unsigned j = 0; j < burst; j++) begin
                if (n_bytes - n_directed >= RANDOM_BYTES - QUIET_TAIL)
                    quiet = 1'b1;
                case ($urandom_range(0, 7))
                    0: bits = 8'h00;
                    1: bits = 8'hFF;
                    default: bits = 8'($urandom);
                endcase
                send_byte(bits, 1'b0, '0);
            end
        end

        drain();
        $display("covered %0d bitmap bytes (%0d directed) giving %0d pixel writes,",
                 n_bytes, n_directed, n_pixels);
        $display("with %0d register writes across %0d settings", n_writes, n_settings);
        if (errors == 0) begin
            $display("mono_bitmap_pixel_expander: match");
        end else begin
            $display("mono_bitmap_pixel_expander: mismatch");
        end
        $finish;
    end

endmodule
